// ===== rtl/aispr_pkg.sv =====
// Shared types, constants and field tables for the AIS position report decoder.
// No dependencies.
`default_nettype none
package aispr_pkg;

  localparam int MAX_BITS_DEFAULT = 168;

  // Highest bit position any decoded field reaches, plus one.
  localparam int SPAN    = 168;
  localparam int SPAN_IW = $clog2(SPAN);

  localparam int VAL_W   = 31;
  localparam int CODE_W  = 5;
  localparam int IDX_W   = 4;
  localparam int FW_W    = 5;

  localparam logic [7:0] CHAR_BIAS  = 8'd48;
  localparam logic [7:0] CHAR_GAP   = 8'd40;
  localparam logic [7:0] CHAR_SKIP  = 8'd8;

  localparam logic [5:0] MSG_POS_A  = 6'd1;
  localparam logic [5:0] MSG_POS_B  = 6'd2;
  localparam logic [5:0] MSG_POS_C  = 6'd3;
  localparam logic [5:0] MSG_BASE   = 6'd4;
  localparam logic [5:0] MSG_UTC    = 6'd11;

  localparam logic [IDX_W-1:0]  IDX_COMMON_LAST = 4'd2;
  localparam logic [IDX_W-1:0]  IDX_FULL_LAST   = 4'd14;
  localparam logic [CODE_W-1:0] BASE_CODE_OFS   = 5'd12;

  localparam int QUEUE_DEPTH = 2;

  typedef logic [SPAN-1:0] msg_bits_t;

  typedef enum logic [1:0] {
    KIND_OTHER,
    KIND_POS,
    KIND_BASE
  } kind_t;

  typedef struct packed {
    logic [SPAN_IW-1:0] start;
    logic [FW_W-1:0]    width;
    logic               sgn;
  } fdesc_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  function automatic fdesc_t mk(input int s, input int w, input bit g);
    fdesc_t d;
    d.start = SPAN_IW'(s);
    d.width = FW_W'(w);
    d.sgn   = g;
    return d;
  endfunction

  function automatic kind_t classify(input logic [5:0] msg_type);
    kind_t k;
    if (msg_type == MSG_POS_A || msg_type == MSG_POS_B || msg_type == MSG_POS_C) begin
      k = KIND_POS;
    end else if (msg_type == MSG_BASE || msg_type == MSG_UTC) begin
      k = KIND_BASE;
    end else begin
      k = KIND_OTHER;
    end
    return k;
  endfunction

  // Field layout: index 0..2 common header, 3..14 per message kind.
  function automatic fdesc_t field_desc(input kind_t kind, input logic [IDX_W-1:0] idx);
    fdesc_t d;
    d = mk(0, 6, 1'b0);
    if (idx == 4'd1) begin
      d = mk(6, 2, 1'b0);
    end else if (idx == 4'd2) begin
      d = mk(8, 30, 1'b0);
    end else if (idx >= 4'd3) begin
      if (kind == KIND_BASE) begin
        unique case (idx)
          4'd3:    d = mk(38, 14, 1'b0);
          4'd4:    d = mk(52, 4, 1'b0);
          4'd5:    d = mk(56, 5, 1'b0);
          4'd6:    d = mk(61, 5, 1'b0);
          4'd7:    d = mk(66, 6, 1'b0);
          4'd8:    d = mk(72, 6, 1'b0);
          4'd9:    d = mk(78, 1, 1'b0);
          4'd10:   d = mk(79, 28, 1'b1);
          4'd11:   d = mk(107, 27, 1'b1);
          4'd12:   d = mk(134, 4, 1'b0);
          4'd13:   d = mk(148, 1, 1'b0);
          default: d = mk(149, 19, 1'b0);
        endcase
      end else begin
        unique case (idx)
          4'd3:    d = mk(38, 4, 1'b0);
          4'd4:    d = mk(42, 8, 1'b1);
          4'd5:    d = mk(50, 10, 1'b0);
          4'd6:    d = mk(60, 1, 1'b0);
          4'd7:    d = mk(61, 28, 1'b1);
          4'd8:    d = mk(89, 27, 1'b1);
          4'd9:    d = mk(116, 12, 1'b0);
          4'd10:   d = mk(128, 9, 1'b0);
          4'd11:   d = mk(137, 6, 1'b0);
          4'd12:   d = mk(143, 2, 1'b0);
          4'd13:   d = mk(148, 1, 1'b0);
          default: d = mk(149, 19, 1'b0);
        endcase
      end
    end
    return d;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/aispr_front.sv =====
// Front end: converts armored characters to six-bit groups and packs them.
// Depends on aispr_pkg.
`default_nettype none
module aispr_front #(
  parameter int MAX_BITS = aispr_pkg::MAX_BITS_DEFAULT
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    take,
  input  wire  [7:0]             ch,
  input  wire                    eom,
  output logic                   push,
  output aispr_pkg::msg_bits_t   push_bits
);
  import aispr_pkg::*;

  localparam int CW = $clog2(MAX_BITS + 1);

  msg_bits_t     store_r, store_nxt, store_upd;
  logic [CW-1:0] count_r, count_nxt;
  logic [7:0]    c;
  logic [5:0]    six;
  logic [CW:0]   pos;
  logic [CW:0]   sum;

  always_comb begin
    c = ch - CHAR_BIAS;
    if (c >= CHAR_GAP) begin
      c = c - CHAR_SKIP;
    end
    six = c[5:0];
  end

  // MSB of the group lands at the lowest bit position; LSB index = position.
  always_comb begin
    store_upd = store_r;
    pos = '0;
    for (int i = 0; i < 6; i++) begin
      pos = {1'b0, count_r} + (CW+1)'(i);
      if (pos < (CW+1)'(SPAN)) begin
        store_upd[pos[SPAN_IW-1:0]] = six[5-i];
      end
    end
    sum = {1'b0, count_r} + (CW+1)'(6);
  end

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    if (take) begin
      if (eom) begin
        store_nxt = '0;
        count_nxt = '0;
      end else begin
        store_nxt = store_upd;
        count_nxt = (sum > (CW+1)'(MAX_BITS)) ? CW'(MAX_BITS) : sum[CW-1:0];
      end
    end
  end

  assign push      = take & eom;
  assign push_bits = store_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      count_r <= '0;
    end else begin
      store_r <= store_nxt;
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aispr_queue.sv =====
// Short queue of complete message bit images between front and back end.
// Depends on aispr_pkg.
`default_nettype none
module aispr_queue (
  input  wire                    clk,
  input  wire                    rst_n,
  input  wire                    push,
  input  aispr_pkg::msg_bits_t   push_bits,
  input  wire                    pop,
  output aispr_pkg::msg_bits_t   head_bits,
  output aispr_pkg::q_stat_t     stat
);
  import aispr_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  msg_bits_t     slot_r [QUEUE_DEPTH];
  logic [PW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [NW-1:0] fill_r, fill_nxt;

  function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
    return (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    wr_nxt   = push ? bump(wr_r) : wr_r;
    rd_nxt   = pop  ? bump(rd_r) : rd_r;
    fill_nxt = fill_r;
    if (push && !pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (pop && !push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  assign head_bits  = slot_r[rd_r];
  assign stat.full  = (fill_r == NW'(QUEUE_DEPTH));
  assign stat.empty = (fill_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r   <= '0;
      rd_r   <= '0;
      fill_r <= '0;
    end else begin
      wr_r   <= wr_nxt;
      rd_r   <= rd_nxt;
      fill_r <= fill_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/aispr_back.sv =====
// Back end: walks the field list of one message image, one field a beat.
// Depends on aispr_pkg.
`default_nettype none
module aispr_back (
  input  wire                         clk,
  input  wire                         rst_n,
  input  aispr_pkg::msg_bits_t        head_bits,
  input  aispr_pkg::q_stat_t          stat,
  output logic                        pop,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic [aispr_pkg::CODE_W-1:0] out_code,
  output logic signed [aispr_pkg::VAL_W-1:0] out_value,
  output logic                        out_last
);
  import aispr_pkg::*;

  msg_bits_t          msg_r, msg_nxt;
  logic               busy_r, busy_nxt;
  kind_t              kind_r, kind_nxt;
  logic [IDX_W-1:0]   idx_r, idx_nxt;
  logic               ov_r, ov_nxt;
  logic [CODE_W-1:0]  code_r, code_nxt;
  logic [VAL_W-1:0]   val_r, val_nxt;
  logic               last_r, last_nxt;

  fdesc_t             d;
  logic [SPAN_IW:0]   top, tap;
  logic               msb;
  logic [VAL_W-1:0]   fval;
  logic [IDX_W-1:0]   idx_last;
  logic               emit;

  // Field bits: position start holds the MSB.
  always_comb begin
    d   = field_desc(kind_r, idx_r);
    top = {1'b0, d.start} + (SPAN_IW+1)'(d.width) - 1'b1;
    msb = msg_r[d.start];
    tap = '0;
    fval = '0;
    for (int k = 0; k < VAL_W; k++) begin
      tap = top - (SPAN_IW+1)'(k);
      if (k < int'(d.width)) begin
        fval[k] = msg_r[tap[SPAN_IW-1:0]];
      end else begin
        fval[k] = d.sgn & msb;
      end
    end
  end

  assign idx_last = (kind_r == KIND_OTHER) ? IDX_COMMON_LAST : IDX_FULL_LAST;
  assign emit     = busy_r && (!ov_r || out_ready);
  assign pop      = !busy_r && !stat.empty;

  always_comb begin
    msg_nxt  = msg_r;
    busy_nxt = busy_r;
    kind_nxt = kind_r;
    idx_nxt  = idx_r;
    ov_nxt   = ov_r;
    code_nxt = code_r;
    val_nxt  = val_r;
    last_nxt = last_r;
    if (ov_r && out_ready) begin
      ov_nxt = 1'b0;
    end
    if (pop) begin
      msg_nxt  = head_bits;
      busy_nxt = 1'b1;
      kind_nxt = classify(head_bits[5:0] == 6'd0 ? 6'd0 :
                          {head_bits[0], head_bits[1], head_bits[2],
                           head_bits[3], head_bits[4], head_bits[5]});
      idx_nxt  = '0;
    end
    if (emit) begin
      ov_nxt   = 1'b1;
      val_nxt  = fval;
      last_nxt = (idx_r == idx_last);
      code_nxt = (kind_r == KIND_BASE && idx_r > IDX_COMMON_LAST)
                 ? CODE_W'(idx_r) + BASE_CODE_OFS : CODE_W'(idx_r);
      if (idx_r == idx_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_code  = code_r;
  assign out_value = val_r;
  assign out_last  = last_r;

  always_ff @(posedge clk) begin
    msg_r  <= msg_nxt;
    kind_r <= kind_nxt;
    idx_r  <= idx_nxt;
    code_r <= code_nxt;
    val_r  <= val_nxt;
    last_r <= last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/ais_position_report_decoder.sv =====
// Top level of the AIS position report decoder.
// Depends on aispr_pkg, aispr_front, aispr_queue and aispr_back.
`default_nettype none
// Takes armored AIS payload characters, one beat per character, and at the
// beat flagged end_of_message emits the decoded fields of that message as a
// run of output beats: type, repeat and MMSI always, then twelve more fields
// for position reports (types 1-3) or base station / UTC reports (types 4, 11),
// with last_field set on the final beat. Bits past position 167 never reach a
// field; bits that never arrived read as zero. Rate: the front end packs one
// character per cycle while in_ready is high. A finished message image moves
// into a two-entry queue; the back end emits one field per cycle from its
// output register while out_ready allows, 3 or 15 fields a message, and loads
// the next image when idle. in_ready drops only while both queue entries hold
// messages not yet started, i.e. when bursts outrun the back end's field walk.
module ais_position_report_decoder #(
  parameter int MAX_BITS = aispr_pkg::MAX_BITS_DEFAULT
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [7:0]                       in_payload_char,
  input  wire                              in_end_of_message,
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [aispr_pkg::CODE_W-1:0]     out_field_code,
  output logic signed [aispr_pkg::VAL_W-1:0] out_field_value,
  output logic                             out_last_field
);
  import aispr_pkg::*;

  logic      take;
  logic      push;
  logic      pop;
  msg_bits_t push_bits;
  msg_bits_t head_bits;
  q_stat_t   stat;

  // Only a closing character needs a queue slot, but holding all input while
  // the queue is full keeps ready independent of the payload.
  assign in_ready = !stat.full;
  assign take     = in_valid && in_ready;

  aispr_front #(
    .MAX_BITS (MAX_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .ch        (in_payload_char),
    .eom       (in_end_of_message),
    .push      (push),
    .push_bits (push_bits)
  );

  aispr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_bits (push_bits),
    .pop       (pop),
    .head_bits (head_bits),
    .stat      (stat)
  );

  aispr_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_bits (head_bits),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_code  (out_field_code),
    .out_value (out_field_value),
    .out_last  (out_last_field)
  );

endmodule
`default_nettype wire
